// ===== rtl/core/bpfa_pkg.sv =====
package bpfa_pkg;

	// default sizing
	localparam int DEF_MAX_FRAMES = 262144;
	localparam int DEF_PAGE_BYTES = 4096;

	// bitmap word organization
	localparam int WORD_BITS = 64;
	localparam int BIT_W     = 6;

	// fixed field widths
	localparam int CFG_W    = 19;
	localparam int CMD_W    = 3;
	localparam int ADDR_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 19;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_MARK_ALL      = 3'd0,
		CMD_FREE_RANGE    = 3'd1,
		CMD_RESERVE_RANGE = 3'd2,
		CMD_ALLOC_PAGE    = 3'd3,
		CMD_FREE_PAGE     = 3'd4
	} cmd_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE    = 2'd0,
		STAT_OOM     = 2'd1,
		STAT_IGNORED = 2'd2
	} status_t;

	// number of set bits in one bitmap word, pairwise adder tree
	function automatic logic [BIT_W:0] popcount_word(input logic [WORD_BITS-1:0] v);
		logic [BIT_W:0] c [WORD_BITS];
		for (int i = 0; i < WORD_BITS; i++) begin
			c[i] = {{BIT_W{1'b0}}, v[i]};
		end
		for (int l = 0; l < BIT_W; l++) begin
			for (int i = 0; i < (WORD_BITS >> (l + 1)); i++) begin
				c[i] = c[2*i] + c[2*i+1];
			end
		end
		return c[0];
	endfunction

	// index of the lowest set bit, binary search over halves
	function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
		logic [WORD_BITS-1:0] w;
		logic [BIT_W-1:0]     idx;
		w   = v;
		idx = '0;
		for (int k = BIT_W - 1; k >= 0; k--) begin
			if ((w & ((WORD_BITS'(1) << (1 << k)) - WORD_BITS'(1))) == '0) begin
				idx[k] = 1'b1;
				w      = w >> (1 << k);
			end
		end
		return idx;
	endfunction

endpackage

// ===== rtl/core/bpfa_ram.sv =====
module bpfa_ram #(
	parameter int WIDTH     = 64,
	parameter int DEPTH     = 4096,
	parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/bitmap_page_frame_allocator_top.sv =====
// channel     | direction | handshake              | payload
// ------------+-----------+------------------------+------------------------------------------
// input       | in        | in_valid / in_ready    | command, address, length
// result      | out       | out_valid / out_ready  | status, page_address, used_count, free_count
// config      | in        | cfg_write_en           | cfg_write_data (frame limit)
//
// a command passes PREP and SETUP, then a read-modify-write of the bitmap RAM per 64-frame
// bitmap word touched, then SETTLE and RESULT, with in_ready rising as the result is registered;
// an unknown command goes from PREP to RESULT. allocate stops at the first word holding a free frame.
// after reset a clearing pass writes all MAX_FRAMES/64 words (4096 at the default) with in_ready
// low; a frame limit write starts a recount through PREP, SETUP and each word below the limit.
// a finished result waits in the output register while the next transfer is accepted.
module bitmap_page_frame_allocator_top #(
	parameter int MAX_FRAMES = bpfa_pkg::DEF_MAX_FRAMES,
	parameter int PAGE_BYTES = bpfa_pkg::DEF_PAGE_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [bpfa_pkg::CFG_W-1:0]    cfg_write_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bpfa_pkg::CMD_W-1:0]    command,
	input  logic [bpfa_pkg::ADDR_W-1:0]   address,
	input  logic [bpfa_pkg::ADDR_W-1:0]   length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bpfa_pkg::STATUS_W-1:0] status,
	output logic [bpfa_pkg::ADDR_W-1:0]   page_address,
	output logic [bpfa_pkg::COUNT_W-1:0]  used_count,
	output logic [bpfa_pkg::COUNT_W-1:0]  free_count
);

	localparam int WORD_BITS  = bpfa_pkg::WORD_BITS;
	localparam int BIT_W      = bpfa_pkg::BIT_W;
	localparam int ADDR_W     = bpfa_pkg::ADDR_W;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int WORDS      = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int FIDX_W     = $clog2(MAX_FRAMES);
	localparam int LIM_W      = $clog2(MAX_FRAMES + 1);
	localparam int CMP_W      = (LIM_W > bpfa_pkg::CFG_W) ? LIM_W : bpfa_pkg::CFG_W;
	localparam int SUM_W      = ADDR_W + 2;
	localparam int RAW_W      = ((SUM_W - PAGE_SHIFT) > (LIM_W + 1)) ?
	                            (SUM_W - PAGE_SHIFT) : (LIM_W + 1);

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_PREP   = 8'b0000_0100,
		S_SETUP  = 8'b0000_1000,
		S_READ   = 8'b0001_0000,
		S_MODIFY = 8'b0010_0000,
		S_SETTLE = 8'b0100_0000,
		S_RESULT = 8'b1000_0000
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE       = 3'd0,
		OP_MARK_ALL   = 3'd1,
		OP_FREE_RANGE = 3'd2,
		OP_RESERVE    = 3'd3,
		OP_ALLOC      = 3'd4,
		OP_FREE_PAGE  = 3'd5,
		OP_COUNT      = 3'd6
	} op_t;

	state_t                     state_q;
	op_t                        op_q;
	logic [ADDR_W-1:0]          addr_q;
	logic [ADDR_W-1:0]          len_q;
	logic [bpfa_pkg::CFG_W-1:0] limit_q;
	logic [RAW_W-1:0]           first_raw_q;
	logic [RAW_W-1:0]           last_raw_q;
	logic [FIDX_W-1:0]          first_q;
	logic [FIDX_W-1:0]          lastm1_q;
	logic [WADDR_W-1:0]         word_q;
	logic [LIM_W-1:0]           count_q;
	logic [BIT_W:0]             delta_q;
	logic                       delta_up_q;
	bpfa_pkg::status_t          status_q;
	logic [ADDR_W-1:0]          page_q;

	logic                         out_valid_q;
	bpfa_pkg::status_t            out_status_q;
	logic [ADDR_W-1:0]            out_page_q;
	logic [bpfa_pkg::COUNT_W-1:0] out_used_q;
	logic [bpfa_pkg::COUNT_W-1:0] out_free_q;

	// effective limit saturates at the bitmap size
	logic [LIM_W-1:0] lim_eff;
	assign lim_eff = (CMP_W'(limit_q) > CMP_W'(MAX_FRAMES)) ?
	                 LIM_W'(MAX_FRAMES) : LIM_W'(limit_q);

	// frame bounds from byte range, base and end rounded per command
	logic [SUM_W-1:0] addr_ext;
	logic [SUM_W-1:0] end_ext;
	logic [SUM_W-1:0] page_m1;
	logic [RAW_W-1:0] prep_first;
	logic [RAW_W-1:0] prep_last;

	assign addr_ext = SUM_W'(addr_q);
	assign end_ext  = SUM_W'(addr_q) + SUM_W'(len_q);
	assign page_m1  = SUM_W'(PAGE_BYTES - 1);

	always_comb begin
		prep_first = '0;
		prep_last  = '1;
		case (op_q)
			OP_FREE_RANGE: begin
				prep_first = RAW_W'((addr_ext + page_m1) >> PAGE_SHIFT);
				prep_last  = RAW_W'(end_ext >> PAGE_SHIFT);
			end
			OP_RESERVE: begin
				prep_first = RAW_W'(addr_ext >> PAGE_SHIFT);
				prep_last  = RAW_W'((end_ext + page_m1) >> PAGE_SHIFT);
			end
			OP_FREE_PAGE: begin
				prep_first = RAW_W'(addr_ext >> PAGE_SHIFT);
				prep_last  = RAW_W'(addr_ext >> PAGE_SHIFT) + RAW_W'(1);
			end
			default: begin
				prep_first = '0;
				prep_last  = '1;
			end
		endcase
	end

	// clip to the limit and check for an empty range
	logic [RAW_W-1:0] lim_raw;
	logic [RAW_W-1:0] last_clip;
	logic             range_empty;

	assign lim_raw     = RAW_W'(lim_eff);
	assign last_clip   = (last_raw_q > lim_raw) ? lim_raw : last_raw_q;
	assign range_empty = (first_raw_q >= last_clip);

	// word window of the current range
	logic [WADDR_W-1:0] first_word;
	logic [WADDR_W-1:0] last_word;

	assign first_word = WADDR_W'(first_q >> BIT_W);
	assign last_word  = WADDR_W'(lastm1_q >> BIT_W);

	// shared word unit: mask, update, count and search
	logic [WORD_BITS-1:0] rd_data;
	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] hi_mask;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] used_in;
	logic [WORD_BITS-1:0] free_in;
	logic [WORD_BITS-1:0] mod_wdata;
	logic                 mod_write;
	logic [BIT_W:0]       mod_delta;
	logic                 mod_up;
	logic                 alloc_found;
	logic [BIT_W-1:0]     alloc_bit;
	logic [FIDX_W-1:0]    alloc_frame;
	logic [FIDX_W+PAGE_SHIFT-1:0] alloc_page_wide;

	assign lo_mask = (word_q == first_word) ? ({WORD_BITS{1'b1}} << first_q[BIT_W-1:0]) :
	                 {WORD_BITS{1'b1}};
	assign hi_mask = (word_q == last_word) ?
	                 ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - lastm1_q[BIT_W-1:0])) :
	                 {WORD_BITS{1'b1}};
	assign mask    = lo_mask & hi_mask;
	assign used_in = rd_data & mask;
	assign free_in = ~rd_data & mask;

	assign alloc_found     = |free_in;
	assign alloc_bit       = bpfa_pkg::lowest_set(free_in);
	assign alloc_frame     = FIDX_W'({word_q, alloc_bit});
	assign alloc_page_wide = {alloc_frame, {PAGE_SHIFT{1'b0}}};

	always_comb begin
		mod_wdata = rd_data;
		mod_write = 1'b0;
		mod_delta = '0;
		mod_up    = 1'b1;
		if (op_q inside {OP_MARK_ALL, OP_RESERVE}) begin
			mod_wdata = rd_data | mask;
			mod_write = 1'b1;
			mod_delta = bpfa_pkg::popcount_word(free_in);
		end else if (op_q inside {OP_FREE_RANGE, OP_FREE_PAGE}) begin
			mod_wdata = rd_data & ~mask;
			mod_write = 1'b1;
			mod_delta = bpfa_pkg::popcount_word(used_in);
			mod_up    = 1'b0;
		end else if (op_q == OP_ALLOC) begin
			mod_wdata = rd_data | (WORD_BITS'(1) << alloc_bit);
			mod_write = alloc_found;
			mod_delta = (BIT_W + 1)'(alloc_found);
		end else if (op_q == OP_COUNT) begin
			mod_delta = bpfa_pkg::popcount_word(used_in);
		end
	end

	// bitmap storage
	logic                 ram_we;
	logic [WORD_BITS-1:0] ram_wdata;

	assign ram_we    = (state_q == S_CLEAR) || ((state_q == S_MODIFY) && mod_write);
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : mod_wdata;

	bpfa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (word_q),
		.wdata (ram_wdata),
		.re    (state_q == S_READ),
		.raddr (word_q),
		.rdata (rd_data)
	);

	assign in_ready = (state_q == S_IDLE) && !cfg_write_en;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			op_q        <= OP_NONE;
			limit_q     <= '0;
			word_q      <= '0;
			count_q     <= '0;
			delta_q     <= '0;
			delta_up_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// running count absorbs the last word's change
			count_q <= delta_up_q ? (count_q + LIM_W'(delta_q)) : (count_q - LIM_W'(delta_q));
			delta_q <= '0;

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					word_q <= word_q + WADDR_W'(1);
					if (word_q == WADDR_W'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid && in_ready) begin
						addr_q   <= address;
						len_q    <= length;
						status_q <= bpfa_pkg::STAT_DONE;
						page_q   <= '0;
						state_q  <= S_PREP;
						case (command)
							bpfa_pkg::CMD_MARK_ALL:      op_q <= OP_MARK_ALL;
							bpfa_pkg::CMD_FREE_RANGE:    op_q <= OP_FREE_RANGE;
							bpfa_pkg::CMD_RESERVE_RANGE: op_q <= OP_RESERVE;
							bpfa_pkg::CMD_ALLOC_PAGE:    op_q <= OP_ALLOC;
							bpfa_pkg::CMD_FREE_PAGE:     op_q <= OP_FREE_PAGE;
							default:                     op_q <= OP_NONE;
						endcase
					end
				end
				S_PREP: begin
					first_raw_q <= prep_first;
					last_raw_q  <= prep_last;
					state_q     <= (op_q == OP_NONE) ? S_RESULT : S_SETUP;
				end
				S_SETUP: begin
					if (range_empty) begin
						if (op_q == OP_FREE_PAGE) begin
							status_q <= bpfa_pkg::STAT_IGNORED;
						end else if (op_q == OP_ALLOC) begin
							status_q <= bpfa_pkg::STAT_OOM;
						end
						state_q <= S_SETTLE;
					end else begin
						first_q  <= FIDX_W'(first_raw_q);
						lastm1_q <= FIDX_W'(last_clip - RAW_W'(1));
						word_q   <= WADDR_W'(first_raw_q >> BIT_W);
						state_q  <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_MODIFY;
				end
				S_MODIFY: begin
					delta_q    <= mod_delta;
					delta_up_q <= mod_up;
					if (op_q == OP_ALLOC && alloc_found) begin
						page_q  <= ADDR_W'(alloc_page_wide);
						state_q <= S_SETTLE;
					end else if (word_q == last_word) begin
						if (op_q == OP_ALLOC) begin
							status_q <= bpfa_pkg::STAT_OOM;
						end else if (op_q == OP_FREE_PAGE && used_in == '0) begin
							status_q <= bpfa_pkg::STAT_IGNORED;
						end
						state_q <= S_SETTLE;
					end else begin
						word_q  <= word_q + WADDR_W'(1);
						state_q <= S_READ;
					end
				end
				S_SETTLE: begin
					state_q <= (op_q == OP_COUNT) ? S_IDLE : S_RESULT;
				end
				S_RESULT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_page_q   <= page_q;
						out_used_q   <= bpfa_pkg::COUNT_W'(count_q);
						out_free_q   <= bpfa_pkg::COUNT_W'(lim_eff - count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// limit write restarts the recount, except during clearing, which leaves the bitmap all zero
			if (cfg_write_en) begin
				limit_q <= cfg_write_data;
				if (state_q != S_CLEAR) begin
					op_q    <= OP_COUNT;
					count_q <= '0;
					delta_q <= '0;
					state_q <= S_PREP;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign page_address = out_page_q;
	assign used_count   = out_used_q;
	assign free_count   = out_free_q;

endmodule

// ===== bench/tb_bitmap_page_frame_allocator_top.sv =====
module tb_bitmap_page_frame_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bpfa_pkg::*;

	localparam int MAX_FRAMES  = DEF_MAX_FRAMES;
	localparam int PAGE_BYTES  = DEF_PAGE_BYTES;
	localparam int FRAME_WORDS = MAX_FRAMES / WORD_BITS;
	localparam int QUIET_LIMIT = 40000;
	localparam int SETTLE_CYCLES = 20;

	// command codes the block has no meaning for
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	// frame limit per random phase, the last one runs without idling
	localparam int PHASES = 14;
	localparam logic [CFG_W-1:0] PHASE_LIMITS [PHASES] = '{
		19'd1, 19'd64, 19'd65, 19'd127, 19'd200, 19'd1000, 19'd4095,
		19'd262144, 19'd524287, 19'd300000, 19'd100, 19'd0, 19'd33, 19'd2048
	};

	typedef struct packed {
		logic [CMD_W-1:0]  opcode;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] len;
	} frame_cmd_t;

	typedef struct packed {
		status_t            code;
		logic [ADDR_W-1:0]  page;
		logic [COUNT_W-1:0] used_n;
		logic [COUNT_W-1:0] free_n;
	} frame_reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_write_en = 1'b0;
	logic [CFG_W-1:0]    cfg_write_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CMD_W-1:0]    command = '0;
	logic [ADDR_W-1:0]   address = '0;
	logic [ADDR_W-1:0]   length = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   page_address;
	logic [COUNT_W-1:0]  used_count;
	logic [COUNT_W-1:0]  free_count;

	// shadow of the allocator state
	bit [WORD_BITS-1:0] frame_bitmap [FRAME_WORDS];
	int unsigned        frames_in_use = 0;
	bit [CFG_W-1:0]     limit_setting = '0;

	frame_cmd_t   cmds_to_send [$];
	frame_reply_t replies_due [$];
	frame_reply_t want;
	int           mismatches = 0;
	int           send_gap = 0;
	int           recv_gap = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	int           quiet_cycles = 0;

	bitmap_page_frame_allocator_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.address        (address),
		.length         (length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.page_address   (page_address),
		.used_count     (used_count),
		.free_count     (free_count)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned active_limit();
		return (limit_setting > MAX_FRAMES) ? MAX_FRAMES : int'(limit_setting);
	endfunction

	function automatic bit frame_is_used(int unsigned f);
		return frame_bitmap[f >> 6][f[5:0]];
	endfunction

	function automatic void frame_set(int unsigned f, bit v);
		frame_bitmap[f >> 6][f[5:0]] = v;
	endfunction

	// count used frames below the current limit
	function automatic void recount_frames();
		int unsigned lim;
		int unsigned n;
		lim = active_limit();
		n = 0;
		for (int unsigned f = 0; f < lim; f++) begin
			n += 32'(frame_is_used(f));
		end
		frames_in_use = n;
	endfunction

	// set or clear frames [first, last) clipped to the limit
	function automatic void mark_span(longint unsigned first, longint unsigned last, bit v);
		longint unsigned lim;
		lim = 64'(active_limit());
		if (last > lim) begin
			last = lim;
		end
		for (longint unsigned f = first; f < last; f++) begin
			if (frame_is_used(32'(f)) != v) begin
				frame_set(32'(f), v);
				if (v) begin
					frames_in_use++;
				end else begin
					frames_in_use--;
				end
			end
		end
	endfunction

	// run one command on the shadow state and form its reply
	function automatic frame_reply_t apply_command(logic [CMD_W-1:0] op, logic [ADDR_W-1:0] addr,
		logic [ADDR_W-1:0] len);
		frame_reply_t    r;
		longint unsigned a;
		longint unsigned l;
		longint unsigned pb;
		longint unsigned fp;
		int unsigned     lim;
		int unsigned     hit;
		bit              found;
		a = 64'(addr);
		l = 64'(len);
		pb = 64'(PAGE_BYTES);
		lim = active_limit();
		hit = 0;
		found = 1'b0;
		r.code = STAT_DONE;
		r.page = '0;
		case (op)
			CMD_MARK_ALL: begin
				mark_span(64'(0), 64'(lim), 1'b1);
			end
			CMD_FREE_RANGE: begin
				mark_span((a + pb - 1) / pb, (a + l) / pb, 1'b0);
			end
			CMD_RESERVE_RANGE: begin
				mark_span(a / pb, (a + l + pb - 1) / pb, 1'b1);
			end
			CMD_ALLOC_PAGE: begin
				// first word with a clear bit, then its lowest clear bit
				for (int unsigned w = 0; w * WORD_BITS < lim && !found; w++) begin
					if (frame_bitmap[w] != '1) begin
						for (int b = 0; b < WORD_BITS && !found; b++) begin
							if (!frame_bitmap[w][b]) begin
								hit = w * WORD_BITS + b;
								found = 1'b1;
							end
						end
					end
				end
				if (found && hit < lim) begin
					frame_set(hit, 1'b1);
					frames_in_use++;
					r.page = ADDR_W'(longint'(hit) * pb);
				end else begin
					r.code = STAT_OOM;
				end
			end
			CMD_FREE_PAGE: begin
				fp = a / pb;
				if (fp < lim && frame_is_used(32'(fp))) begin
					frame_set(32'(fp), 1'b0);
					frames_in_use--;
				end else begin
					r.code = STAT_IGNORED;
				end
			end
			default: begin
			end
		endcase
		r.used_n = COUNT_W'(frames_in_use);
		r.free_n = COUNT_W'(lim - frames_in_use);
		return r;
	endfunction

	function automatic frame_cmd_t cmd_of(logic [CMD_W-1:0] op, logic [ADDR_W-1:0] addr,
		logic [ADDR_W-1:0] len);
		frame_cmd_t c;
		c.opcode = op;
		c.addr = addr;
		c.len = len;
		return c;
	endfunction

	// mostly page-aligned traffic around the managed frames, some raw noise
	function automatic frame_cmd_t random_command(int unsigned lim);
		frame_cmd_t  c;
		int unsigned span;
		int unsigned pick;
		int unsigned frame;
		int unsigned pages;
		span = (lim == 0) ? 1 : lim;
		pick = $urandom_range(0, 99);
		frame = $urandom_range(0, span + span / 8 + 1);
		pages = $urandom_range(0, (span < 64) ? span : 64);
		c.addr = ADDR_W'(frame * PAGE_BYTES);
		c.len = ADDR_W'(pages * PAGE_BYTES);
		if ($urandom_range(0, 3) == 0) begin
			c.addr += ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
		end
		if ($urandom_range(0, 3) == 0) begin
			c.len += ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
		end
		if ($urandom_range(0, 15) == 0) begin
			c.addr = $urandom();
		end
		if ($urandom_range(0, 15) == 0) begin
			c.len = $urandom();
		end
		if (pick < 35) begin
			c.opcode = CMD_ALLOC_PAGE;
		end else if (pick < 65) begin
			c.opcode = CMD_FREE_PAGE;
		end else if (pick < 80) begin
			c.opcode = CMD_FREE_RANGE;
		end else if (pick < 93) begin
			c.opcode = CMD_RESERVE_RANGE;
		end else if (pick < 97) begin
			c.opcode = CMD_MARK_ALL;
		end else begin
			c.opcode = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
		end
		return c;
	endfunction

	// wait until nothing is queued, presented or owed
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (cmds_to_send.size() != 0 || in_valid || replies_due.size() != 0);
	endtask

	task automatic write_frame_limit(logic [CFG_W-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		limit_setting = value;
		recount_frames();
		@(negedge clk);
	endtask

	// command driver, predicts each reply when its transfer happens
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				replies_due.push_back(apply_command(command, address, length));
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
					send_gap = $urandom_range(0, 11);
					in_valid <= 1'b0;
				end else if (cmds_to_send.size() != 0) begin
					frame_cmd_t c;
					c = cmds_to_send.pop_front();
					in_valid <= 1'b1;
					command <= c.opcode;
					address <= c.addr;
					length <= c.len;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// reply monitor with random back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: unexpected reply status %0d page %h used %0d free %0d", $time,
						status, page_address, used_count, free_count);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					if (status != want.code) begin
						$display("%0t: status expected %0d, got %0d", $time, want.code, status);
						mismatches++;
					end
					if (page_address != want.page) begin
						$display("%0t: page_address expected %h, got %h", $time, want.page,
							page_address);
						mismatches++;
					end
					if (used_count != want.used_n) begin
						$display("%0t: used_count expected %0d, got %0d", $time, want.used_n,
							used_count);
						mismatches++;
					end
					if (free_count != want.free_n) begin
						$display("%0t: free_count expected %0d, got %0d", $time, want.free_n,
							free_count);
						mismatches++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
				recv_gap = $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// reset, directed commands, then random phases over several limits
	initial begin
		int unsigned lim;
		int          count;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// nothing managed at the reset limit
		send_idle_pct = 12;
		recv_idle_pct = 12;
		cmds_to_send.push_back(cmd_of(CMD_ALLOC_PAGE, '0, '0));
		cmds_to_send.push_back(cmd_of(CMD_FREE_PAGE, '0, '0));
		cmds_to_send.push_back(cmd_of(CMD_MARK_ALL, '0, '0));
		cmds_to_send.push_back(cmd_of(CMD_RESERVE_RANGE, '0, '1));

		write_frame_limit(19'd100);
		cmds_to_send.push_back(cmd_of(CMD_ALLOC_PAGE, '0, '0));
		cmds_to_send.push_back(cmd_of(CMD_ALLOC_PAGE, '1, '1));
		// outward rounding reaches one more frame, inward rounding clears it again
		cmds_to_send.push_back(cmd_of(CMD_RESERVE_RANGE, 32'h1800, 32'h1000));
		cmds_to_send.push_back(cmd_of(CMD_FREE_RANGE, 32'h1001, 32'h2000));
		// range with no whole frame inside
		cmds_to_send.push_back(cmd_of(CMD_FREE_RANGE, 32'h1001, 32'h10));
		cmds_to_send.push_back(cmd_of(CMD_FREE_PAGE, 32'h1000, '0));
		cmds_to_send.push_back(cmd_of(CMD_FREE_PAGE, 32'h1000, '0));
		// page beyond the limit and the top of the address space
		cmds_to_send.push_back(cmd_of(CMD_FREE_PAGE, 32'h64000, '0));
		cmds_to_send.push_back(cmd_of(CMD_FREE_PAGE, '1, '0));
		cmds_to_send.push_back(cmd_of(CMD_MARK_ALL, '0, '0));
		cmds_to_send.push_back(cmd_of(CMD_ALLOC_PAGE, '0, '0));
		// range ends reaching and passing the 32-bit limit
		cmds_to_send.push_back(cmd_of(CMD_FREE_RANGE, '0, '1));
		cmds_to_send.push_back(cmd_of(CMD_RESERVE_RANGE, 32'hFFFFF000, '1));
		cmds_to_send.push_back(cmd_of(CMD_RESERVE_RANGE, '0, '0));
		cmds_to_send.push_back(cmd_of(CMD_RESERVE_RANGE, 32'h5, '0));
		cmds_to_send.push_back(cmd_of(CMD_UNUSED_LO, $urandom(), $urandom()));
		cmds_to_send.push_back(cmd_of(CMD_UNUSED_HI, '1, '1));
		cmds_to_send.push_back(cmd_of(CMD_ALLOC_PAGE, '0, '0));
		cmds_to_send.push_back(cmd_of(CMD_ALLOC_PAGE, '0, '0));

		for (int p = 0; p < PHASES; p++) begin
			write_frame_limit(PHASE_LIMITS[p]);
			lim = active_limit();
			if (p == PHASES - 1) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else begin
				send_idle_pct = $urandom_range(0, 2) * 12;
				recv_idle_pct = $urandom_range(0, 2) * 12;
			end
			// full-size bitmaps are slow, keep those phases short
			count = (lim > 8192) ? 10 : 75;
			for (int i = 0; i < count; i++) begin
				cmds_to_send.push_back(random_command(lim));
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
